@@ hw/rtl/osil_pkg.sv @@
// Shared types, constants and decode functions for the operator/string/integer lexer.
`timescale 1ns / 1ps

package osil_pkg;

  // Width of the internal byte position counter
  localparam int POS_WIDTH = 16;
  // Width of the position fields on the result channel
  localparam int POS_OUT_W = 16;
  localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

  // Result queue depth and derived widths
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Byte codes used by the scanner
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Token kinds
  localparam logic [4:0] KIND_STRING = 5'd0;
  localparam logic [4:0] KIND_INT    = 5'd1;
  localparam logic [4:0] KIND_NONE   = 5'd0;

  // Scanner mode, one-hot
  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_OP   = 4'b0010,
    MODE_STR  = 4'b0100,
    MODE_NUM  = 4'b1000
  } mode_t;

  // One result item
  typedef struct packed {
    logic [4:0]           kind;
    logic [POS_OUT_W-1:0] start_pos;
    logic [POS_OUT_W-1:0] end_pos;
    logic                 error;
    logic                 final_res;
  } res_t;

  // Results produced by one accepted byte
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } push_t;

  // Kind of a single-character operator, KIND_NONE if not an operator
  function automatic logic [4:0] single_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      8'h2B:   k = 5'd2;   // +
      8'h2D:   k = 5'd3;   // -
      8'h2F:   k = 5'd4;   // /
      8'h2A:   k = 5'd5;   // *
      8'h25:   k = 5'd6;   // %
      8'h3D:   k = 5'd7;   // =
      8'h3E:   k = 5'd8;   // >
      8'h3C:   k = 5'd9;   // <
      8'h21:   k = 5'd10;  // !
      8'h28:   k = 5'd11;  // (
      8'h29:   k = 5'd12;  // )
      8'h5B:   k = 5'd13;  // [
      8'h5D:   k = 5'd14;  // ]
      8'h7B:   k = 5'd15;  // {
      8'h7D:   k = 5'd16;  // }
      8'h0A:   k = 5'd17;  // newline
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

  // Kind of c followed by '=', KIND_NONE if c cannot open a pair
  function automatic logic [4:0] pair_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      8'h2B:   k = 5'd18;  // +=
      8'h2D:   k = 5'd19;  // -=
      8'h3E:   k = 5'd20;  // >=
      8'h3C:   k = 5'd21;  // <=
      8'h2F:   k = 5'd22;  // /=
      8'h2A:   k = 5'd23;  // *=
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Position counter value to output field: truncate or zero-extend
  function automatic logic [POS_OUT_W-1:0] to_field(input logic [POS_WIDTH-1:0] p);
    logic [POS_WIDTH+POS_OUT_W-1:0] ext;
    ext = {{POS_OUT_W{1'b0}}, p};
    return ext[POS_OUT_W-1:0];
  endfunction

endpackage

@@ hw/rtl/osil_core.sv @@
// Scanner state registers and per-byte token decode.
`timescale 1ns / 1ps

module osil_core
  import osil_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] ch,
  input  logic       last_char,
  output push_t      push
);

  logic [POS_WIDTH-1:0] pos_r, pos_nxt;
  logic [POS_WIDTH-1:0] tstart_r, tstart_nxt;
  logic [7:0]           held_r, held_nxt;
  mode_t                mode_r, mode_nxt;

  // Candidate results: from the open token, from the idle handler, from end of input
  res_t                 e1, e2, e3;
  logic                 v1, v2, v3;
  logic                 run_idle;
  mode_t                mode_mid;
  logic [POS_WIDTH-1:0] tstart_mid;
  logic [7:0]           held_mid;
  logic [POS_WIDTH-1:0] num_end;
  logic [4:0]           sk;

  // Byte decode
  always_comb begin
    e1         = '0;
    e2         = '0;
    e3         = '0;
    v1         = 1'b0;
    v2         = 1'b0;
    v3         = 1'b0;
    run_idle   = 1'b0;
    mode_mid   = mode_r;
    tstart_mid = tstart_r;
    held_mid   = held_r;
    num_end    = (pos_r > tstart_r) ? pos_r - 1'b1 : tstart_r;
    sk         = single_kind(ch);

    // Open token
    case (mode_r)
      MODE_OP: begin
        v1           = 1'b1;
        e1.start_pos = to_field(tstart_r);
        mode_mid     = MODE_IDLE;
        if (ch == CH_EQ) begin
          e1.kind    = pair_kind(held_r);
          e1.end_pos = to_field(pos_r);
        end else begin
          e1.kind    = single_kind(held_r);
          e1.end_pos = to_field(tstart_r);
          run_idle   = 1'b1;
        end
      end
      MODE_STR: begin
        if (ch == CH_QUOTE) begin
          v1           = 1'b1;
          e1.kind      = KIND_STRING;
          e1.start_pos = to_field(tstart_r);
          e1.end_pos   = to_field(pos_r);
          mode_mid     = MODE_IDLE;
        end
      end
      MODE_NUM: begin
        if (!is_digit(ch)) begin
          v1           = 1'b1;
          e1.kind      = KIND_INT;
          e1.start_pos = to_field(tstart_r);
          e1.end_pos   = to_field(num_end);
          mode_mid     = MODE_IDLE;
          run_idle     = 1'b1;
        end
      end
      default: run_idle = 1'b1;
    endcase

    // Idle handling of the byte
    if (run_idle) begin
      if (ch == CH_QUOTE) begin
        mode_mid   = MODE_STR;
        tstart_mid = pos_r;
      end else if (is_digit(ch)) begin
        mode_mid   = MODE_NUM;
        tstart_mid = pos_r;
      end else if (pair_kind(ch) != KIND_NONE) begin
        mode_mid   = MODE_OP;
        held_mid   = ch;
        tstart_mid = pos_r;
      end else if (sk != KIND_NONE) begin
        v2           = 1'b1;
        e2.kind      = sk;
        e2.start_pos = to_field(pos_r);
        e2.end_pos   = to_field(pos_r);
      end
    end

    // End of input flushes the open token
    if (last_char) begin
      case (mode_mid)
        MODE_OP: begin
          v3           = 1'b1;
          e3.kind      = single_kind(held_mid);
          e3.start_pos = to_field(tstart_mid);
          e3.end_pos   = to_field(tstart_mid);
        end
        MODE_NUM: begin
          v3           = 1'b1;
          e3.kind      = KIND_INT;
          e3.start_pos = to_field(tstart_mid);
          e3.end_pos   = to_field(pos_r);
        end
        MODE_STR: begin
          v3       = 1'b1;
          e3.error = 1'b1;
        end
        default: v3 = 1'b0;
      endcase
    end
  end

  // Pack candidates into up to two results; idle and flush results exclude each other
  always_comb begin
    push = '0;
    if (v1) begin
      push.r0 = e1;
      if (v2) begin
        push.r1  = e2;
        push.num = 2'd2;
      end else if (v3) begin
        push.r1  = e3;
        push.num = 2'd2;
      end else begin
        push.num = 2'd1;
      end
    end else if (v2) begin
      push.r0  = e2;
      push.num = 2'd1;
    end else if (v3) begin
      push.r0  = e3;
      push.num = 2'd1;
    end
    if (push.num == 2'd2) begin
      push.r1.final_res = 1'b1;
    end else if (push.num == 2'd1) begin
      push.r0.final_res = 1'b1;
    end
    if (!fire) begin
      push.num = 2'd0;
    end
  end

  // Next state
  always_comb begin
    pos_nxt    = pos_r;
    tstart_nxt = tstart_r;
    held_nxt   = held_r;
    mode_nxt   = mode_r;
    if (fire) begin
      if (last_char) begin
        pos_nxt    = '0;
        tstart_nxt = '0;
        held_nxt   = '0;
        mode_nxt   = MODE_IDLE;
      end else begin
        pos_nxt    = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
        tstart_nxt = tstart_mid;
        held_nxt   = held_mid;
        mode_nxt   = mode_mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      tstart_r <= '0;
      held_r   <= '0;
      mode_r   <= MODE_IDLE;
    end else begin
      pos_r    <= pos_nxt;
      tstart_r <= tstart_nxt;
      held_r   <= held_nxt;
      mode_r   <= mode_nxt;
    end
  end

endmodule

@@ hw/rtl/osil_outq.sv @@
// Small result queue: takes up to two results per cycle, hands out one.
`timescale 1ns / 1ps

module osil_outq
  import osil_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,
  output logic  valid,
  input  logic  pop,
  output res_t  head
);

  res_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_pop;
  logic [QPTR_W-1:0] wr_p1;

  assign valid  = (cnt_r != '0);
  assign head   = q_r[rd_r];
  assign do_pop = pop && valid;
  // Room for the worst case of two results
  assign room   = (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign wr_p1  = wr_r + 1'b1;

  // Pointers and fill count
  always_comb begin
    wr_nxt  = wr_r + QPTR_W'(push.num);
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + QCNT_W'(push.num) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      q_r[wr_r] <= push.r0;
    end
    if (push.num == 2'd2) begin
      q_r[wr_p1] <= push.r1;
    end
  end

endmodule

@@ hw/rtl/operator_string_integer_lexer.sv @@
// Top level of the operator, string and integer lexer.
//
//   Channel | Ports              | Contents
//   --------+--------------------+-----------------------------------------------
//   input   | in_tvalid/tready   | tdata: ch[7:0]; tlast: last_char
//   result  | out_tvalid/tready  | tdata: start_pos[15:0], end_pos[31:16];
//           |                    | tuser: token_kind[4:0], error[5]; tlast: final_res
//
// One byte is taken per cycle while the queue has room; its results are in the queue
// the cycle after. A byte may yield two results while the queue drains one per cycle,
// so bytes that give two results hold back the input on a free-running output.
// in_tready drops when the four-entry result queue lacks room for two results.
// Reset (synchronous, rst_n low) clears position, mode and the queue; no clearing pass.
`timescale 1ns / 1ps

module operator_string_integer_lexer
  import osil_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,   // last_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] start_pos, [31:16] end_pos
  output logic [5:0]  out_tuser,  // [4:0] token_kind, [5] error
  output logic        out_tlast   // final_res
);

  logic  fire;
  push_t push;
  res_t  head;
  logic  room;

  assign fire      = in_tvalid && in_tready;
  assign in_tready = room;

  osil_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .ch        (in_tdata),
    .last_char (in_tlast),
    .push      (push)
  );

  osil_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .room  (room),
    .valid (out_tvalid),
    .pop   (out_tready),
    .head  (head)
  );

  // Result packing
  assign out_tdata = {head.end_pos, head.start_pos};
  assign out_tuser = {head.error, head.kind};
  assign out_tlast = head.final_res;

endmodule

@@ sim/tb_operator_string_integer_lexer.sv @@
// Operator, string and integer lexer testbench: directed and random streams checked per token.
`timescale 1ns / 1ps

module tb_operator_string_integer_lexer
  import osil_pkg::*;
;

  // Operator bytes, listed in token kind order
  localparam int N_SINGLE = 16;
  localparam int N_PAIR   = 6;
  localparam logic [8*N_SINGLE-1:0] SINGLE_OPS = "+-/*%=><!()[]{}\n";
  localparam logic [8*N_PAIR-1:0]   PAIR_OPS   = "+-></*";
  localparam logic [4:0] KIND_SINGLE_FIRST = 5'd2;
  localparam logic [4:0] KIND_PAIR_FIRST   = 5'd18;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_ITEMS   = 600;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } src_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] ch
  logic        in_tlast = 1'b0; // last_char
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [15:0] start_pos, [31:16] end_pos
  logic [5:0]  out_tuser;       // [4:0] token_kind, [5] error
  logic        out_tlast;       // final_res

  // Source bytes waiting to be sent, tokens waiting to come out
  src_byte_t src_q[$];
  res_t      token_q[$];

  // Lexer state as the testbench sees it
  logic [POS_WIDTH-1:0] tok_pos = '0;
  mode_t                tok_mode = MODE_IDLE;
  logic [POS_WIDTH-1:0] tok_start = '0;
  logic [7:0]           held_op = '0;
  res_t                 step_res[2];
  int                   step_n;

  int n_bytes_in = 0;
  int n_tokens_out = 0;
  int fail_count = 0;
  int idle_cycles = 0;
  int tx_gap = 0;
  int tx_calm = 0;
  int rx_hold = 0;
  int rx_calm = 0;
  bit squeeze_done = 1'b0;

  operator_string_integer_lexer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  // Byte decode
  function automatic logic [4:0] op_single_kind(input logic [7:0] c);
    logic [4:0] k;
    k = KIND_NONE;
    for (int i = 0; i < N_SINGLE; i++)
      if (SINGLE_OPS[8*(N_SINGLE-1-i) +: 8] == c) k = KIND_SINGLE_FIRST + 5'(i);
    return k;
  endfunction

  function automatic logic [4:0] op_pair_kind(input logic [7:0] c);
    logic [4:0] k;
    k = KIND_NONE;
    for (int i = 0; i < N_PAIR; i++)
      if (PAIR_OPS[8*(N_PAIR-1-i) +: 8] == c) k = KIND_PAIR_FIRST + 5'(i);
    return k;
  endfunction

  function automatic bit is_numeral(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // Record one token of the current byte; a byte yields two at most
  function automatic void note_token(input logic [4:0] kind, input logic [POS_WIDTH-1:0] s,
                                     input logic [POS_WIDTH-1:0] e, input logic err);
    if (step_n < 2) begin
      step_res[step_n].kind      = kind;
      step_res[step_n].start_pos = POS_OUT_W'(s);
      step_res[step_n].end_pos   = POS_OUT_W'(e);
      step_res[step_n].error     = err;
      step_res[step_n].final_res = 1'b0;
      step_n++;
    end
  endfunction

  // A byte seen with nothing open
  function automatic void scan_idle(input logic [7:0] c, input logic [POS_WIDTH-1:0] p);
    if (c == CH_QUOTE) begin
      tok_mode  = MODE_STR;
      tok_start = p;
    end else if (is_numeral(c)) begin
      tok_mode  = MODE_NUM;
      tok_start = p;
    end else if (op_pair_kind(c) != KIND_NONE) begin
      tok_mode  = MODE_OP;
      held_op   = c;
      tok_start = p;
    end else if (op_single_kind(c) != KIND_NONE) begin
      note_token(op_single_kind(c), p, p, 1'b0);
    end
  endfunction

  // Advance the lexer by one accepted byte and queue the tokens it yields
  function automatic void lex_byte(input logic [7:0] c, input logic last);
    logic [POS_WIDTH-1:0] p;
    p = tok_pos;
    step_n = 0;
    case (tok_mode)
      MODE_OP: begin
        if (c == CH_EQ) begin
          note_token(op_pair_kind(held_op), tok_start, p, 1'b0);
          tok_mode = MODE_IDLE;
        end else begin
          note_token(op_single_kind(held_op), tok_start, tok_start, 1'b0);
          tok_mode = MODE_IDLE;
          scan_idle(c, p);
        end
      end
      MODE_STR: begin
        if (c == CH_QUOTE) begin
          note_token(KIND_STRING, tok_start, p, 1'b0);
          tok_mode = MODE_IDLE;
        end
      end
      MODE_NUM: begin
        if (!is_numeral(c)) begin
          // a saturated position can leave the end below the start
          note_token(KIND_INT, tok_start, (p > tok_start) ? p - 1'b1 : tok_start, 1'b0);
          tok_mode = MODE_IDLE;
          scan_idle(c, p);
        end
      end
      default: scan_idle(c, p);
    endcase

    // End of source: flush the open token, then back to reset state
    if (last) begin
      case (tok_mode)
        MODE_OP:  note_token(op_single_kind(held_op), tok_start, tok_start, 1'b0);
        MODE_NUM: note_token(KIND_INT, tok_start, p, 1'b0);
        MODE_STR: note_token(KIND_NONE, '0, '0, 1'b1);
        default: ;
      endcase
      tok_pos   = '0;
      tok_mode  = MODE_IDLE;
      tok_start = '0;
      held_op   = '0;
    end else if (tok_pos != POS_MAX) begin
      tok_pos = tok_pos + 1'b1;
    end

    if (step_n > 0) step_res[step_n-1].final_res = 1'b1;
    for (int i = 0; i < step_n; i++) token_q.push_back(step_res[i]);
  endfunction

  // Stimulus helpers
  function automatic void put_byte(input logic [7:0] c, input logic last);
    src_byte_t b;
    b.ch   = c;
    b.last = last;
    src_q.push_back(b);
  endfunction

  function automatic void put_text(input string s, input bit ends_source);
    for (int i = 0; i < s.len(); i++) put_byte(s[i], ends_source && i == s.len() - 1);
  endfunction

  function automatic logic [7:0] rand_skip_char();
    logic [7:0] c;
    do
      c = 8'($urandom_range(0, 255));
    while (op_single_kind(c) != KIND_NONE || is_numeral(c) || c == CH_QUOTE);
    return c;
  endfunction

  // Mostly lexable bytes, some skipped bytes and raw noise
  function automatic logic [7:0] rand_lex_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 28) return CH_ZERO + 8'($urandom_range(0, 9));
    if (r < 48) return SINGLE_OPS[8*$urandom_range(0, N_SINGLE-1) +: 8];
    if (r < 58) return PAIR_OPS[8*$urandom_range(0, N_PAIR-1) +: 8];
    if (r < 68) return CH_EQ;
    if (r < 75) return CH_QUOTE;
    if (r < 88) return rand_skip_char();
    return 8'($urandom_range(0, 255));
  endfunction

  // One random source; returns the number of bytes queued
  function automatic int rand_frame(input int max_len);
    int len;
    logic [7:0] c;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90) : $urandom_range(1, max_len);
    for (int i = 0; i < len; i++) begin
      c = rand_lex_char();
      put_byte(c, i == len - 1);
    end
    return len;
  endfunction

  // Stimulus, reset and end of run
  initial begin
    int made;
    // all single operators, pending operators closed by another byte
    put_text("+-/*>< =%!()[]{}\n", 1'b1);
    // all pair operators back to back
    put_text("+=-=>=<=/=*=", 1'b1);
    // string with a high byte, number ended by an op, a zero byte, number at end
    put_byte(CH_QUOTE, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(CH_QUOTE, 1'b0);
    put_text("09)", 1'b0);
    put_byte(8'h00, 1'b0);
    put_text("7", 1'b1);
    // open string at end, pending op at end
    put_text("\"x", 1'b1);
    put_text("*", 1'b1);

    made = 0;
    while (made < RANDOM_ITEMS) made += rand_frame(24);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (src_q.size() != 0 || in_tvalid || token_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[operator_string_integer_lexer] OK");
    end else begin
      $display("[operator_string_integer_lexer] ERROR");
    end
    $finish;
  end

  // Sender: predict on acceptance, then offer the next byte, at times after a random gap
  always @(posedge clk) begin
    src_byte_t b;
    int r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tlast  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        lex_byte(in_tdata, in_tlast);
        n_bytes_in++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (src_q.size() != 0) begin
          b = src_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= b.ch;
          in_tlast  <= b.last;
          if (tx_calm > 0) begin
            tx_calm--;
          end else begin
            r = $urandom_range(0, 99);
            if (r < 2) tx_calm = $urandom_range(30, 200);
            else if (r < 10) tx_gap = $urandom_range(1, 3);
            else if (r < 12) tx_gap = $urandom_range(8, 30);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Receiver: check each token, drive ready with random stalls and one long hold-off
  always @(posedge clk) begin
    res_t want;
    int r;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_tokens_out++;
        if (token_q.size() == 0) begin
          $error("unexpected token: kind %0d start %0d end %0d error %0d",
                 out_tuser[4:0], out_tdata[15:0], out_tdata[31:16], out_tuser[5]);
          fail_count++;
        end else begin
          want = token_q.pop_front();
          check_field("token_kind", want.kind, out_tuser[4:0]);
          check_field("start_pos", want.start_pos, out_tdata[15:0]);
          check_field("end_pos", want.end_pos, out_tdata[31:16]);
          check_field("error", want.error, out_tuser[5]);
          check_field("final_res", want.final_res, out_tlast);
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else if (!squeeze_done && n_bytes_in >= 120) begin
        // long hold-off so the result queue fills and input stalls
        squeeze_done = 1'b1;
        rx_hold = SQUEEZE_CYCLES;
        out_tready <= 1'b0;
      end else if (rx_calm > 0) begin
        rx_calm--;
        out_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          rx_hold = $urandom_range(8, 40);
          out_tready <= 1'b0;
        end else if (r < 5) begin
          rx_calm = $urandom_range(30, 150);
          out_tready <= 1'b1;
        end else begin
          out_tready <= (r >= 30);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[operator_string_integer_lexer] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
